// ===== rtl/spn16_block_encrypt_macros.svh =====
// Assertion macros shared by the spn16 block cipher checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef SPN16_BLOCK_ENCRYPT_MACROS_SVH
`define SPN16_BLOCK_ENCRYPT_MACROS_SVH

// implication checked outside reset
`define SPN16_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked at every edge, reset included
`define SPN16_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/spn16_pkg.sv =====
// Types, constants and round functions of the spn16 block cipher.
// No dependencies; imported by the cell and the top level.
`default_nettype none

package spn16_pkg;

   localparam int NUM_CELLS = 4;
   localparam int BLOCK_W   = 16;
   localparam int KEY_W     = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [0:0] CSR_IDX_KEY = 1'b0;

   localparam logic [3:0] SBOX_TABLE [16] = '{
      4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
      4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7
   };

   typedef struct packed {
      logic [BLOCK_W-1:0] round_key;
      logic [BLOCK_W-1:0] final_key;
      logic               permute;
   } spn16_cell_cfg_type;

   function automatic logic [3:0] sbox_nibble(input logic [3:0] n);
      logic [3:0] idx;
      logic [3:0] s;
      idx = {n[0], n[1], n[2], n[3]};
      s   = SBOX_TABLE[idx];
      return {s[0], s[1], s[2], s[3]};
   endfunction

   function automatic logic [BLOCK_W-1:0] subst_word(input logic [BLOCK_W-1:0] x);
      logic [BLOCK_W-1:0] y;
      for (int i = 0; i < 4; i++) begin
         y[4*i +: 4] = sbox_nibble(x[4*i +: 4]);
      end
      return y;
   endfunction

   function automatic logic [BLOCK_W-1:0] perm_word(input logic [BLOCK_W-1:0] x);
      logic [BLOCK_W-1:0] y;
      for (int a = 0; a < 4; a++) begin
         for (int b = 0; b < 4; b++) begin
            y[15 - (4*b + a)] = x[15 - (4*a + b)];
         end
      end
      return y;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/spn16_block_encrypt.sv =====
// Datapath: each of the four round cells registers the block once between request acceptance and rsp_valid.
// Throughput: one request per cycle while rsp_ready is high; each cell holds its block until taken.
// Reset: synchronous, active high; empties every cell and clears the key to 0.
// Top level of the spn16 block cipher: APB key register and a chain of four
// round cells. Depends on spn16_pkg and spn16_cell.
`default_nettype none

module spn16_block_encrypt
   import spn16_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [15:0]           req_plaintext_block,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [15:0]                rsp_ciphertext_block,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   logic             key_sel;

   spn16_cell_cfg_type cell_cfg [NUM_CELLS];
   logic               link_valid [NUM_CELLS+1];
   logic               link_ready [NUM_CELLS+1];
   logic [BLOCK_W-1:0] link_data  [NUM_CELLS+1];

   assign csr_pready = 1'b1;
   assign key_sel    = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_KEY);

   always_comb begin
      key_in = key_ff;
      if (csr_psel && csr_penable && csr_pwrite && key_sel) begin
         key_in = csr_pwdata;
      end
      csr_prdata = key_sel ? key_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign link_valid[0] = req_valid;
   assign req_ready     = link_ready[0];
   assign link_data[0]  = req_plaintext_block;

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      assign cell_cfg[g].round_key = key_ff[KEY_W-1-4*g -: BLOCK_W];
      assign cell_cfg[g].final_key = (g == NUM_CELLS-1) ? key_ff[BLOCK_W-1:0] : '0;
      assign cell_cfg[g].permute   = (g != NUM_CELLS-1);

      spn16_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cfg       (cell_cfg[g]),
         .in_valid  (link_valid[g]),
         .in_ready  (link_ready[g]),
         .in_data   (link_data[g]),
         .out_valid (link_valid[g+1]),
         .out_ready (link_ready[g+1]),
         .out_data  (link_data[g+1])
      );
   end

   assign rsp_valid             = link_valid[NUM_CELLS];
   assign link_ready[NUM_CELLS] = rsp_ready;
   assign rsp_ciphertext_block  = link_data[NUM_CELLS];

endmodule

`default_nettype wire

// ===== rtl/spn16_cell.sv =====
// One round cell of the spn16 chain: key mix, S-box, then transpose or, in the last cell, a final key mix.
// Depends on spn16_pkg; instantiated by spn16_block_encrypt.
`default_nettype none

module spn16_cell
   import spn16_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire spn16_cell_cfg_type cfg,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic [BLOCK_W-1:0] in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic [BLOCK_W-1:0]      out_data
);

   logic               valid_ff;
   logic               valid_in;
   logic [BLOCK_W-1:0] data_ff;
   logic [BLOCK_W-1:0] data_in;
   logic [BLOCK_W-1:0] mixed;

   always_comb begin
      mixed    = subst_word(in_data ^ cfg.round_key);
      in_ready = !valid_ff || out_ready;
      valid_in = in_ready ? in_valid : valid_ff;
      if (cfg.permute) begin
         data_in = perm_word(mixed);
      end else begin
         data_in = mixed ^ cfg.final_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/spn16_checker.sv =====
// Port-level checker for spn16_block_encrypt, bound to the top level.
// Depends on spn16_block_encrypt_macros.svh.
`default_nettype none
`include "spn16_block_encrypt_macros.svh"

module spn16_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_ciphertext_block,
   input wire logic        csr_pready
);

   `SPN16_ASSERT_IMPL(a_pready_high, 1'b1, csr_pready, "csr_pready dropped")
   `SPN16_ASSERT_NEXT(a_reset_empty, reset, !rsp_valid, "response after reset")
   `SPN16_ASSERT_IMPL(a_empty_takes, !rsp_valid, req_ready, "empty chain refused request")
   `SPN16_ASSERT_IMPL(a_rsp_hold, $past(rsp_valid && !rsp_ready && !reset),
      rsp_valid && $stable(rsp_ciphertext_block), "stalled response changed")

endmodule

bind spn16_block_encrypt spn16_checker u_spn16_checker (.*);

`default_nettype wire
